FILE: hw/rtl/periodic_callback_timer_table_assert.svh
// ----------------------------------------------------------------------------
// Timer table assertion macros
// Concurrent check macros for the timer table. Assertions are elaborated
// in simulation only and compile to nothing for synthesis. They sample on
// i_clk and are held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_CALLBACK_TIMER_TABLE_ASSERT_SVH
`define PERIODIC_CALLBACK_TIMER_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PCBT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pcbt: same-cycle check failed");
// next-cycle implication
`define PCBT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pcbt: next-cycle check failed");
`else
`define PCBT_ASSERT_IMP(lbl, ante, cons)
`define PCBT_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: hw/rtl/pcbt_pkg.sv
// ----------------------------------------------------------------------------
// Timer table package
// Shared widths, codes and beat types of the periodic callback timer table.
// ----------------------------------------------------------------------------
package pcbt_pkg;

    // default sizing
    localparam int SLOTS_DEF       = 16;
    localparam int PERIOD_BITS_DEF = 16;

    // field widths
    localparam int CMD_W       = 2;
    localparam int ID_W        = 8;
    localparam int IN_PERIOD_W = 16;
    localparam int KIND_W      = 2;
    localparam int SLOT_W      = 4;
    localparam int MARKS_W     = 6;
    localparam int ENTRY_W     = 5;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 24;

    // tick dividers
    localparam int DIV_A      = 10;
    localparam int DIV_B      = 20;
    localparam int DIV_C      = 100;
    localparam int DIV_D      = 500;
    localparam int PHASE_WRAP = 1000;
    localparam int DIV_A_W    = $clog2(DIV_A);
    localparam int DIV_B_W    = $clog2(DIV_B);
    localparam int DIV_C_W    = $clog2(DIV_C);
    localparam int DIV_D_W    = $clog2(DIV_D);
    localparam int PHASE_W    = $clog2(PHASE_WRAP);

    // mark bit positions
    localparam int MARK_1    = 0;
    localparam int MARK_A    = 1;
    localparam int MARK_B    = 2;
    localparam int MARK_C    = 3;
    localparam int MARK_D    = 4;
    localparam int MARK_WRAP = 5;

    // register acknowledge status
    localparam logic STAT_OK   = 1'b0;
    localparam logic STAT_FULL = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_REG   = 2'd1,
        CMD_UNREG = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [KIND_W-1:0] {
        KIND_FIRE  = 2'd0,
        KIND_MARKS = 2'd1,
        KIND_ACK   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } t_state;

    // classified command beat
    typedef struct packed {
        t_cmd                   cmd;
        logic [ID_W-1:0]        id;
        logic [IN_PERIOD_W-1:0] period;
    } t_cmd_item;

    // result beat
    typedef struct packed {
        t_kind               kind;
        logic [ID_W-1:0]     id;
        logic [SLOT_W-1:0]   slot;
        logic [MARKS_W-1:0]  marks;
        logic                status;
        logic [ENTRY_W-1:0]  entries;
        logic                last;
    } t_result;

endpackage

FILE: hw/rtl/periodic_callback_timer_table.sv
// ----------------------------------------------------------------------------
// Periodic callback timer table
// Table of periodic timers driven by tick, register and unregister beats.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s side): one beat per command, tuser holds the command
//   (tick, register, unregister, other codes are acknowledged only), tdata
//   holds callback id and period. Output stream (m side): tuser holds the
//   result kind, tlast marks the final beat of each command.
//   A tick gives one fire beat per used entry that expires with a nonzero
//   id, in slot order, then one tick-marks beat. Register and unregister
//   give a single acknowledge beat.
//   One command is in the engine at a time. Register and other
//   non-walking commands go from idle straight to the finish state,
//   which gives their acknowledge. Tick and unregister walk the N entries
//   in use, one table read per cycle while no fire beat is stalled, then
//   finish; a tick's fire beats come during the walk, an unregister's
//   acknowledge in the finish state. Reset empties the table and zeroes the
//   tick phase at once. A stalled receiver backs up the two-beat result
//   queue, the engine, the two-beat command queue and finally tready.
// ----------------------------------------------------------------------------
`include "periodic_callback_timer_table_assert.svh"

module periodic_callback_timer_table
    import pcbt_pkg::*;
#(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // [7:0] callback_id, [23:8] period
    input  logic [CMD_W-1:0]      i_s_tuser,   // [1:0] command
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // [7:0] fired_id, [11:8] fired_slot,
                                               // [17:12] tick_marks, [18] status,
                                               // [23:19] entries_in_use
    output logic [KIND_W-1:0]     o_m_tuser,   // [1:0] kind
    output logic                  o_m_tlast
);

    logic      cmd_valid;
    logic      cmd_pop;
    t_cmd_item cmd;
    logic      res_valid;
    logic      res_ready;
    t_result   res;
    t_result   out_res;

    // command intake
    pcbt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // table engine
    pcbt_engine #(
        .SLOTS       (SLOTS),
        .PERIOD_BITS (PERIOD_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    // result queue
    pcbt_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .o_res_ready (res_ready),
        .i_res       (res),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_res       (out_res)
    );

    // output packing
    assign o_m_tdata = {out_res.entries, out_res.status, out_res.marks,
                        out_res.slot, out_res.id};
    assign o_m_tuser = out_res.kind;
    assign o_m_tlast = out_res.last;

    // checks
    `PCBT_ASSERT_IMP(a_pop_has_cmd, cmd_pop, cmd_valid)
    `PCBT_ASSERT_NXT(a_one_cmd_at_a_time, cmd_pop, !cmd_pop)
    `PCBT_ASSERT_IMP(a_fire_not_last, o_m_tvalid && (o_m_tuser == KIND_FIRE), !o_m_tlast)
    `PCBT_ASSERT_IMP(a_count_in_range, o_m_tvalid, out_res.entries <= SLOTS)

endmodule

FILE: hw/rtl/pcbt_front.sv
// ----------------------------------------------------------------------------
// Timer table front end
// Takes command beats from the input stream, classifies the command code
// and holds up to two commands for the table engine.
// ----------------------------------------------------------------------------
module pcbt_front
    import pcbt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [IN_DATA_W-1:0] i_s_tdata,   // [7:0] callback_id, [23:8] period
    input  logic [CMD_W-1:0]     i_s_tuser,   // [1:0] command
    output logic                 o_cmd_valid,
    output t_cmd_item            o_cmd,
    input  logic                 i_cmd_pop
);

    logic [1:0] r_level;
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    t_cmd_item  r_slot [2];

    logic       push;
    logic       pop;
    t_cmd_item  in_item;

    // classify the incoming beat
    always_comb begin
        in_item.cmd    = t_cmd'(i_s_tuser);
        in_item.id     = i_s_tdata[ID_W-1:0];
        in_item.period = i_s_tdata[ID_W +: IN_PERIOD_W];
    end

    assign o_s_tready  = (r_level != 2'd2);
    assign push        = i_s_tvalid && o_s_tready;
    assign o_cmd_valid = (r_level != 2'd0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_slot[r_rd_ptr];

    // queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level  <= 2'd0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({push, pop})
                2'b10:   r_level <= r_level + 2'd1;
                2'b01:   r_level <= r_level - 2'd1;
                default: r_level <= r_level;
            endcase
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= in_item;
        end
    end

endmodule

FILE: hw/rtl/pcbt_obuf.sv
// ----------------------------------------------------------------------------
// Timer table result buffer
// Two-beat queue between the table engine and the output stream, so the
// engine can hand over up to two beats while the receiver stalls.
// ----------------------------------------------------------------------------
module pcbt_obuf
    import pcbt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_res_valid,
    output logic    o_res_ready,
    input  t_result i_res,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic [1:0] r_level;
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    t_result    r_slot [2];

    logic       push;
    logic       pop;

    assign o_res_ready = (r_level != 2'd2);
    assign push        = i_res_valid && o_res_ready;
    assign o_valid     = (r_level != 2'd0);
    assign pop         = o_valid && i_ready;
    assign o_res       = r_slot[r_rd_ptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level  <= 2'd0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({push, pop})
                2'b10:   r_level <= r_level + 2'd1;
                2'b01:   r_level <= r_level - 2'd1;
                default: r_level <= r_level;
            endcase
        end
    end

    // beat storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_res;
        end
    end

endmodule

FILE: hw/rtl/pcbt_engine.sv
// ----------------------------------------------------------------------------
// Timer table engine
// Holds the timer table in a memory and carries out one command at a time:
// appends on register, walks the used slots on tick and unregister, and
// keeps the divided tick phase.
// ----------------------------------------------------------------------------
module pcbt_engine
    import pcbt_pkg::*;
#(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd_item i_cmd,
    output logic      o_cmd_pop,
    output logic      o_res_valid,
    output t_result   o_res,
    input  logic      i_res_ready
);

    localparam int CW = $clog2(SLOTS + 1);
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

    typedef struct packed {
        logic [ID_W-1:0]        id;
        logic [PERIOD_BITS-1:0] period;
        logic [PERIOD_BITS-1:0] elapsed;
    } t_entry;

    // table memory
    t_entry m_table [SLOTS];

    t_state               r_state, n_state;
    t_cmd_item            r_cmd;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_rd_idx;
    logic [CW-1:0]        r_kept, n_kept;
    logic                 r_p_vld;
    logic [AW-1:0]        r_p_idx;
    t_entry               r_rd_data;
    logic                 r_full;
    logic [DIV_A_W-1:0]   r_div_a;
    logic [DIV_B_W-1:0]   r_div_b;
    logic [DIV_C_W-1:0]   r_div_c;
    logic [DIV_D_W-1:0]   r_div_d;
    logic [PHASE_W-1:0]   r_phase;

    logic                 is_tick;
    logic                 pop;
    logic                 reg_ok;
    logic [PERIOD_BITS-1:0] p_inc;
    logic                 p_hit;
    logic                 p_emit;
    logic                 p_keep;
    logic                 stall;
    logic                 adv;
    logic                 more;
    logic                 rd_issue;
    logic                 walk_done;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    t_entry               wr_data;
    logic [MARKS_W-1:0]   marks;
    logic                 commit_tick;

    // walk datapath terms
    assign is_tick   = (r_cmd.cmd == CMD_TICK);
    assign p_inc     = r_rd_data.elapsed + PERIOD_BITS'(1);
    assign p_hit     = (p_inc >= r_rd_data.period);
    assign p_emit    = (r_state == ST_WALK) && r_p_vld && is_tick && p_hit
                       && (r_rd_data.id != '0);
    assign p_keep    = !is_tick && (r_rd_data.id != r_cmd.id);
    assign stall     = p_emit && !i_res_ready;
    assign adv       = (r_state == ST_WALK) && !stall;
    assign more      = (r_rd_idx != r_count);
    assign rd_issue  = adv && more;
    assign walk_done = adv && !more;
    assign rd_addr   = r_rd_idx[AW-1:0];
    assign pop       = (r_state == ST_IDLE) && i_cmd_valid;
    assign reg_ok    = (r_count != SLOTS_C);
    assign o_cmd_pop = pop;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.cmd) inside
                        CMD_TICK, CMD_UNREG: n_state = ST_WALK;
                        default:             n_state = ST_FINISH;
                    endcase
                end
            end
            ST_WALK: begin
                if (walk_done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // table writes: append on register, write-back or compaction on walk
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_p_idx;
        wr_data = r_rd_data;
        if (pop && (i_cmd.cmd == CMD_REG) && reg_ok) begin
            wr_en           = 1'b1;
            wr_addr         = r_count[AW-1:0];
            wr_data.id      = i_cmd.id;
            wr_data.period  = PERIOD_BITS'(i_cmd.period);
            wr_data.elapsed = '0;
        end else if (adv && r_p_vld && is_tick) begin
            wr_en           = 1'b1;
            wr_data.elapsed = p_hit ? '0 : p_inc;
        end else if (adv && r_p_vld && p_keep) begin
            wr_en   = 1'b1;
            wr_addr = r_kept[AW-1:0];
        end
    end

    // entry count and compaction index
    always_comb begin
        n_kept  = r_kept;
        n_count = r_count;
        if (pop) begin
            n_kept = '0;
            if ((i_cmd.cmd == CMD_REG) && reg_ok) begin
                n_count = r_count + CW'(1);
            end
        end else if (adv && r_p_vld && p_keep) begin
            n_kept = r_kept + CW'(1);
        end
        if (walk_done && !is_tick) begin
            n_count = n_kept;
        end
    end

    // tick marks from the divided phase counters
    always_comb begin
        marks            = '0;
        marks[MARK_1]    = 1'b1;
        marks[MARK_A]    = (r_div_a == DIV_A_W'(DIV_A - 1));
        marks[MARK_B]    = (r_div_b == DIV_B_W'(DIV_B - 1));
        marks[MARK_C]    = (r_div_c == DIV_C_W'(DIV_C - 1));
        marks[MARK_D]    = (r_div_d == DIV_D_W'(DIV_D - 1));
        marks[MARK_WRAP] = (r_phase == PHASE_W'(PHASE_WRAP - 1));
    end

    assign commit_tick = (r_state == ST_FINISH) && i_res_ready && is_tick;

    // result beats
    always_comb begin
        o_res_valid   = 1'b0;
        o_res.kind    = KIND_ACK;
        o_res.id      = '0;
        o_res.slot    = '0;
        o_res.marks   = '0;
        o_res.status  = STAT_OK;
        o_res.entries = ENTRY_W'(r_count);
        o_res.last    = 1'b1;
        unique case (r_state)
            ST_WALK: begin
                o_res_valid = p_emit;
                o_res.kind  = KIND_FIRE;
                o_res.id    = r_rd_data.id;
                o_res.slot  = SLOT_W'(r_p_idx);
                o_res.last  = 1'b0;
            end
            ST_FINISH: begin
                o_res_valid = 1'b1;
                if (is_tick) begin
                    o_res.kind  = KIND_MARKS;
                    o_res.marks = marks;
                end else begin
                    o_res.status = r_full;
                end
            end
            default: o_res_valid = 1'b0;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_rd_idx <= '0;
            r_kept   <= '0;
            r_p_vld  <= 1'b0;
            r_full   <= STAT_OK;
            r_div_a  <= '0;
            r_div_b  <= '0;
            r_div_c  <= '0;
            r_div_d  <= '0;
            r_phase  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_kept  <= n_kept;
            if (pop) begin
                r_rd_idx <= '0;
                r_p_vld  <= 1'b0;
                r_full   <= ((i_cmd.cmd == CMD_REG) && !reg_ok) ? STAT_FULL : STAT_OK;
            end else if (adv) begin
                r_p_vld <= rd_issue;
                if (rd_issue) begin
                    r_rd_idx <= r_rd_idx + CW'(1);
                end
            end
            if (commit_tick) begin
                r_div_a <= marks[MARK_A]    ? '0 : r_div_a + DIV_A_W'(1);
                r_div_b <= marks[MARK_B]    ? '0 : r_div_b + DIV_B_W'(1);
                r_div_c <= marks[MARK_C]    ? '0 : r_div_c + DIV_C_W'(1);
                r_div_d <= marks[MARK_D]    ? '0 : r_div_d + DIV_D_W'(1);
                r_phase <= marks[MARK_WRAP] ? '0 : r_phase + PHASE_W'(1);
            end
        end
    end

    // command and walk payload
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cmd <= i_cmd;
        end
        if (rd_issue) begin
            r_p_idx <= rd_addr;
        end
    end

    // memory write port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            m_table[wr_addr] <= wr_data;
        end
    end

    // memory read port
    always_ff @(posedge i_clk) begin
        if (rd_issue) begin
            r_rd_data <= m_table[rd_addr];
        end
    end

endmodule
